// File: rtl/svk_pkg.sv
// Shared types, constants and saturation helper for the SVK stress and energy block.
package svk_pkg;

    localparam int NUM_COMP = 6;   // symmetric tensor: 11 22 33 12 13 23
    localparam int NUM_ROW  = 3;

    // Row/column of each symmetric component, in output order.
    localparam int COMP_I [NUM_COMP] = '{0, 1, 2, 0, 0, 1};
    localparam int COMP_J [NUM_COMP] = '{0, 1, 2, 1, 2, 2};

    // Configuration register indexes.
    localparam logic [1:0] REG_DIMENSION_MODE    = 2'd0;
    localparam logic [1:0] REG_LAME_FIRST        = 2'd1;
    localparam logic [1:0] REG_SHEAR_MODULUS     = 2'd2;
    localparam logic [1:0] REG_THERMAL_EXPANSION = 2'd3;

    localparam logic signed [42:0] Q24_ONE = 43'sd16777216;

    typedef struct packed {
        logic signed [31:0] f11;
        logic signed [31:0] f12;
        logic signed [31:0] f13;
        logic signed [31:0] f21;
        logic signed [31:0] f22;
        logic signed [31:0] f23;
        logic signed [31:0] f31;
        logic signed [31:0] f32;
        logic signed [31:0] f33;
        logic signed [31:0] temperature;
    } operand_t;

    typedef struct packed {
        logic signed [31:0] s11;
        logic signed [31:0] s22;
        logic signed [31:0] s33;
        logic signed [31:0] s12;
        logic signed [31:0] s13;
        logic signed [31:0] s23;
        logic signed [31:0] strain_energy;
    } result_t;

    // Strain handed from the strain front end to the constitutive back end.
    typedef struct packed {
        logic                             valid;
        logic [NUM_COMP-1:0][31:0]        mech;     // strain without thermal term
        logic [NUM_COMP-1:0][31:0]        stress;   // strain used for stress
    } strain_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -48'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// File: rtl/svk_stress_and_energy.sv
// Top level: configuration registers, strain front end and constitutive back end.
// done goes high as an accepted item leaves the last register stage.
// Throughput: one item per cycle; six register stages, each with one rank of
// 32x32 multipliers or one add-and-saturate level. busy is never raised.
// Results show for one cycle on done; the receiver cannot stall.
// Reset (rst_n low) clears the valid bits and the configuration registers; datapath
// registers are not reset.
module svk_stress_and_energy
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  svk_pkg::operand_t      operand,
    output logic                   done,
    output svk_pkg::result_t       result,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);

    logic               mode_reg;
    logic signed [31:0] lambda_reg;
    logic signed [31:0] mu_reg;
    logic signed [31:0] beta_reg;
    logic               accept;
    svk_pkg::strain_t   strain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            lambda_reg <= '0;
            mu_reg     <= '0;
            beta_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svk_pkg::REG_DIMENSION_MODE:    mode_reg   <= cfg_data[0];
                svk_pkg::REG_LAME_FIRST:        lambda_reg <= cfg_data;
                svk_pkg::REG_SHEAR_MODULUS:     mu_reg     <= cfg_data;
                svk_pkg::REG_THERMAL_EXPANSION: beta_reg   <= cfg_data;
                default:                        mode_reg   <= mode_reg;
            endcase
        end
    end

    // Fully pipelined: every start is a transfer.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    svk_strain u_strain
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (accept),
        .operand (operand),
        .mode3d  (mode_reg),
        .beta    (beta_reg),
        .strain  (strain)
    );

    svk_law u_law
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .strain  (strain),
        .mode3d  (mode_reg),
        .lambda  (lambda_reg),
        .mu      (mu_reg),
        .done    (done),
        .result  (result)
    );

endmodule

// File: rtl/svk_strain.sv
// Green strain front end: Q8.24 products of F, then strain sums, thermal offset, saturation.
module svk_strain
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    input  svk_pkg::operand_t      operand,
    input  logic                   mode3d,
    input  logic signed [31:0]     beta,
    output svk_pkg::strain_t       strain
);

    logic signed [31:0] f [svk_pkg::NUM_ROW][svk_pkg::NUM_ROW];

    logic signed [39:0] prod_next [svk_pkg::NUM_COMP][svk_pkg::NUM_ROW];
    logic signed [39:0] prod_reg  [svk_pkg::NUM_COMP][svk_pkg::NUM_ROW];
    logic signed [39:0] bt_next;
    logic signed [39:0] bt_reg;
    logic               v1_reg;

    svk_pkg::strain_t   strain_next;
    logic [svk_pkg::NUM_COMP-1:0][31:0] mech_reg;
    logic [svk_pkg::NUM_COMP-1:0][31:0] stress_reg;
    logic               v2_reg;

    assign f[0][0] = operand.f11;
    assign f[0][1] = operand.f12;
    assign f[0][2] = operand.f13;
    assign f[1][0] = operand.f21;
    assign f[1][1] = operand.f22;
    assign f[1][2] = operand.f23;
    assign f[2][0] = operand.f31;
    assign f[2][1] = operand.f32;
    assign f[2][2] = operand.f33;

    // Stage 1: column dot-product terms F_ki*F_kj >>> 24, thermal offset beta*T >>> 24 (2D mode only).
    always_comb
    begin
        logic signed [63:0] p;
        logic signed [63:0] pb;
        for (int c = 0; c < svk_pkg::NUM_COMP; c++)
        begin
            for (int k = 0; k < svk_pkg::NUM_ROW; k++)
            begin
                p = 64'(f[k][svk_pkg::COMP_I[c]]) * 64'(f[k][svk_pkg::COMP_J[c]]);
                if (!mode3d && (k == 2 || svk_pkg::COMP_J[c] == 2))
                    prod_next[c][k] = '0;
                else
                    prod_next[c][k] = p[63:24];
            end
        end
        pb = 64'(beta) * 64'(operand.temperature);
        bt_next = mode3d ? '0 : pb[63:24];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        bt_reg   <= bt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= valid;
    end

    // Stage 2: C sum, subtract identity, halve, subtract thermal offset on the diagonal for stress, saturate to Q8.24.
    always_comb
    begin
        logic signed [41:0] csum;
        logic signed [42:0] cm;
        logic signed [41:0] e;
        logic signed [42:0] et;
        logic               diag;
        logic               unused;
        strain_next.valid = v1_reg;
        for (int c = 0; c < svk_pkg::NUM_COMP; c++)
        begin
            diag   = (svk_pkg::COMP_I[c] == svk_pkg::COMP_J[c]);
            unused = !mode3d && (svk_pkg::COMP_J[c] == 2);
            csum = 42'(prod_reg[c][0]) + 42'(prod_reg[c][1]) + 42'(prod_reg[c][2]);
            cm   = 43'(csum) - (diag ? svk_pkg::Q24_ONE : 43'sd0);
            e    = cm[42:1];
            et   = 43'(e) - (diag ? 43'(bt_reg) : 43'sd0);
            if (unused)
            begin
                strain_next.mech[c]   = '0;
                strain_next.stress[c] = '0;
            end
            else
            begin
                strain_next.mech[c]   = svk_pkg::sat32(48'(e));
                strain_next.stress[c] = svk_pkg::sat32(48'(et));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mech_reg   <= strain_next.mech;
        stress_reg <= strain_next.stress;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= strain_next.valid;
    end

    assign strain = '{valid: v2_reg, mech: mech_reg, stress: stress_reg};

endmodule

// File: rtl/svk_law.sv
// Constitutive back end: traces, squares, moduli products, stress and energy with saturation.
module svk_law
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  svk_pkg::strain_t       strain,
    input  logic                   mode3d,
    input  logic signed [31:0]     lambda,
    input  logic signed [31:0]     mu,
    output logic                   done,
    output svk_pkg::result_t       result
);

    // Stage 3
    logic signed [31:0] es3_next  [svk_pkg::NUM_COMP];
    logic signed [31:0] es3_reg   [svk_pkg::NUM_COMP];
    logic signed [39:0] sq3_next  [svk_pkg::NUM_COMP];
    logic signed [39:0] sq3_reg   [svk_pkg::NUM_COMP];
    logic signed [31:0] trs3_next, trs3_reg;
    logic signed [31:0] trm3_next, trm3_reg;
    logic               v3_reg;

    // Stage 4
    logic signed [40:0] a4_next [svk_pkg::NUM_COMP];
    logic signed [40:0] a4_reg  [svk_pkg::NUM_COMP];
    logic signed [39:0] lt4_next, lt4_reg;
    logic signed [39:0] tm4_next, tm4_reg;
    logic signed [31:0] q4_next,  q4_reg;
    logic               v4_reg;

    // Stage 5
    logic signed [31:0] s5_next [svk_pkg::NUM_COMP];
    logic signed [31:0] s5_reg  [svk_pkg::NUM_COMP];
    logic signed [38:0] wl5_next, wl5_reg;
    logic signed [39:0] wm5_next, wm5_reg;
    logic               v5_reg;

    // Stage 6 (output)
    svk_pkg::result_t   result_next;
    svk_pkg::result_t   result_reg;
    logic               done_reg;

    // Stage 3: traces of the stress and mechanical strain, squares of the mechanical strain.
    always_comb
    begin
        logic signed [63:0] p;
        logic signed [33:0] ts;
        logic signed [33:0] tm;
        for (int c = 0; c < svk_pkg::NUM_COMP; c++)
        begin
            es3_next[c] = strain.stress[c];
            p = 64'($signed(strain.mech[c])) * 64'($signed(strain.mech[c]));
            sq3_next[c] = p[63:24];
        end
        ts = 34'($signed(strain.stress[0])) + 34'($signed(strain.stress[1]))
           + 34'($signed(strain.stress[2]));
        tm = 34'($signed(strain.mech[0])) + 34'($signed(strain.mech[1]))
           + 34'($signed(strain.mech[2]));
        trs3_next = svk_pkg::sat32(48'(ts));
        trm3_next = svk_pkg::sat32(48'(tm));
    end

    // Stage 4: 2*mu*E, lambda*tr, tr^2, and the E:E sum (off-diagonals twice).
    always_comb
    begin
        logic signed [63:0] p;
        logic signed [63:0] pl;
        logic signed [63:0] pt;
        logic signed [44:0] qs;
        for (int c = 0; c < svk_pkg::NUM_COMP; c++)
        begin
            p = 64'(mu) * 64'(es3_reg[c]);
            a4_next[c] = p[63:23];
        end
        pl = 64'(lambda) * 64'(trs3_reg);
        lt4_next = pl[63:24];
        pt = 64'(trm3_reg) * 64'(trm3_reg);
        tm4_next = pt[63:24];
        qs = 45'(sq3_reg[0]) + 45'(sq3_reg[1]) + 45'(sq3_reg[2])
           + ((45'(sq3_reg[3]) + 45'(sq3_reg[4]) + 45'(sq3_reg[5])) <<< 1);
        q4_next = svk_pkg::sat32(48'(qs));
    end

    // Stage 5: stress sums; energy products on saturated t2 and q.
    always_comb
    begin
        logic signed [41:0] sv;
        logic signed [31:0] t2;
        logic signed [63:0] pl;
        logic signed [63:0] pm;
        for (int c = 0; c < svk_pkg::NUM_COMP; c++)
        begin
            if (svk_pkg::COMP_I[c] == svk_pkg::COMP_J[c])
                sv = 42'(a4_reg[c]) + 42'(lt4_reg);
            else
                sv = 42'(a4_reg[c]);
            // in 2D, s33 (which would carry lambda*tr), s13 and s23 are forced to zero
            if (!mode3d && svk_pkg::COMP_J[c] == 2)
                s5_next[c] = '0;
            else
                s5_next[c] = svk_pkg::sat32(48'(sv));
        end
        t2 = svk_pkg::sat32(48'(tm4_reg));
        pl = 64'(lambda) * 64'(t2);
        pm = 64'(mu) * 64'(q4_reg);
        wl5_next = pl[63:25];
        wm5_next = pm[63:24];
    end

    // Stage 6: energy sum and output assembly.
    always_comb
    begin
        logic signed [40:0] ws;
        ws = 41'(wl5_reg) + 41'(wm5_reg);
        result_next.s11           = s5_reg[0];
        result_next.s22           = s5_reg[1];
        result_next.s33           = s5_reg[2];
        result_next.s12           = s5_reg[3];
        result_next.s13           = s5_reg[4];
        result_next.s23           = s5_reg[5];
        result_next.strain_energy = svk_pkg::sat32(48'(ws));
    end

    always_ff @(posedge clk)
    begin
        es3_reg    <= es3_next;
        sq3_reg    <= sq3_next;
        trs3_reg   <= trs3_next;
        trm3_reg   <= trm3_next;
        a4_reg     <= a4_next;
        lt4_reg    <= lt4_next;
        tm4_reg    <= tm4_next;
        q4_reg     <= q4_next;
        s5_reg     <= s5_next;
        wl5_reg    <= wl5_next;
        wm5_reg    <= wm5_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v3_reg   <= strain.valid;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: test/svk_stress_and_energy_tb.sv
// Self-checking testbench for the St. Venant-Kirchhoff stress and strain energy block.
`timescale 1ns / 100ps

module svk_stress_and_energy_tb;

    import svk_pkg::*;

    localparam int     PIPE_DEPTH  = 6;
    localparam int     CYCLE_LIMIT = 250000;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 135;
    localparam longint UNIT_Q24    = 64'sd16777216;

    localparam logic signed [31:0] ONE  = 32'sd16777216;
    localparam logic signed [31:0] HALF = 32'sd8388608;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    operand_t    operand = '0;
    logic        done;
    result_t     result;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_DIMENSION_MODE;
    logic [31:0] cfg_data = '0;

    // register shadow used by the stress predictor
    bit     mode_3d;
    longint lame_q;
    longint mu_q;
    longint beta_q;

    result_t expected_stress [$];
    int      mismatches;
    int      cycle_count;
    bit      start_held;
    bit      no_gaps;

    // indexed like a [6:0][31:0] view of result_t
    string field_name [7] = '{"strain_energy", "s23", "s13", "s12", "s33", "s22", "s11"};

    svk_stress_and_energy dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic result_t predict_stress(operand_t op);
        longint  fg [3][3];
        longint  em [3][3];
        longint  es [3][3];
        longint  sg [3][3];
        longint  bt, trs, trm, t2, q, w, c, e, v;
        int      dim;
        result_t r;
        fg[0][0] = op.f11; fg[0][1] = op.f12; fg[0][2] = op.f13;
        fg[1][0] = op.f21; fg[1][1] = op.f22; fg[1][2] = op.f23;
        fg[2][0] = op.f31; fg[2][1] = op.f32; fg[2][2] = op.f33;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                em[i][j] = 0;
                es[i][j] = 0;
                sg[i][j] = 0;
            end
        dim = mode_3d ? 3 : 2;
        bt = 0;
        if (!mode_3d)
            bt = (beta_q * longint'(op.temperature)) >>> 24;

        // Green strain, upper triangle mirrored; thermal offset on the diagonal only
        for (int i = 0; i < dim; i++)
            for (int j = i; j < dim; j++)
            begin
                c = 0;
                for (int k = 0; k < dim; k++)
                    c += (fg[k][i] * fg[k][j]) >>> 24;
                e = (c - ((i == j) ? UNIT_Q24 : 64'sd0)) >>> 1;
                em[i][j] = clamp32(e);
                es[i][j] = clamp32((i == j) ? e - bt : e);
                em[j][i] = em[i][j];
                es[j][i] = es[i][j];
            end

        trs = 0;
        trm = 0;
        for (int i = 0; i < dim; i++)
        begin
            trs += es[i][i];
            trm += em[i][i];
        end
        trs = clamp32(trs);
        trm = clamp32(trm);

        for (int i = 0; i < dim; i++)
            for (int j = 0; j < dim; j++)
            begin
                v = (mu_q * es[i][j]) >>> 23;
                if (i == j)
                    v += (lame_q * trs) >>> 24;
                sg[i][j] = clamp32(v);
            end

        t2 = clamp32((trm * trm) >>> 24);
        q = 0;
        for (int i = 0; i < dim; i++)
            for (int j = 0; j < dim; j++)
                q += (em[i][j] * em[i][j]) >>> 24;
        q = clamp32(q);
        w = clamp32(((lame_q * t2) >>> 25) + ((mu_q * q) >>> 24));

        r.s11 = sg[0][0][31:0];
        r.s22 = sg[1][1][31:0];
        r.s33 = sg[2][2][31:0];
        r.s12 = sg[0][1][31:0];
        r.s13 = sg[0][2][31:0];
        r.s23 = sg[1][2][31:0];
        r.strain_energy = w[31:0];
        return r;
    endfunction

    // compare every strobed result with the oldest prediction
    always @(posedge clk)
    begin : check_result
        result_t          want;
        logic [6:0][31:0] want_w;
        logic [6:0][31:0] got_w;
        if (rst_n && done)
        begin
            if (expected_stress.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: %h", cycle_count, result);
            end
            else
            begin
                want = expected_stress.pop_front();
                want_w = want;
                got_w = result;
                for (int k = 0; k < 7; k++)
                    if (want_w[k] !== got_w[k])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %s at cycle %0d: expected %h got %h",
                                     field_name[k], cycle_count, want_w[k], got_w[k]);
                    end
            end
        end
    end

    function automatic logic signed [31:0] jitter(int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic release_start();
        if (start_held)
        begin
            start <= 1'b0;
            start_held = 0;
        end
    endtask

    task automatic pace_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 60);
        if (n > 0)
        begin
            release_start();
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue_tensor(operand_t op);
        operand <= op;
        start <= 1'b1;
        start_held = 1;
        do @(posedge clk); while (busy !== 1'b0);
        expected_stress.push_back(predict_stress(op));
        pace_gap();
    endtask

    // hold off until every pending result has come out of the pipe
    task automatic quiesce();
        release_start();
        while (expected_stress.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic put_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_DIMENSION_MODE:    mode_3d = data[0];
            REG_LAME_FIRST:        lame_q = $signed(data);
            REG_SHEAR_MODULUS:     mu_q = $signed(data);
            REG_THERMAL_EXPANSION: beta_q = $signed(data);
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] mode_word, logic [31:0] lame,
                              logic [31:0] mu, logic [31:0] beta);
        quiesce();
        put_reg(REG_DIMENSION_MODE, mode_word);
        put_reg(REG_LAME_FIRST, lame);
        put_reg(REG_SHEAR_MODULUS, mu);
        put_reg(REG_THERMAL_EXPANSION, beta);
        cfg_we <= 1'b0;
    endtask

    function automatic operand_t random_tensor();
        logic [9:0][31:0] pk;
        int               style;
        style = $urandom_range(0, 99);
        for (int k = 0; k < 9; k++)
        begin
            if (style < 55)
                pk[9 - k] = ((k % 4 == 0) ? ONE : 32'sd0) + jitter(1 << 22);
            else if (style < 75)
                pk[9 - k] = jitter(1 << 26);
            else
                pk[9 - k] = $urandom();
        end
        pk[0] = $urandom_range(0, 1) ? jitter(1 << 25) : 32'($urandom());
        return operand_t'(pk);
    endfunction

    // registers at reset: everything must come out zero
    task automatic test_reset_state();
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0});
        issue_tensor(operand_t'{HALF, ONE, MAXV, MINV, HALF, ONE, 3, 5, 7, ONE});
    endtask

    task automatic test_plane_thermal();
        set_config(32'h0000_0000, 32'sd65536, 32'sd32768, 32'sd167772);
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0});
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE});
        issue_tensor(operand_t'{ONE + HALF, 0, 0, 0, ONE, 0, 0, 0, ONE, -ONE});
        issue_tensor(operand_t'{ONE, ONE / 4, MAXV, MINV, ONE, MAXV, MINV, MAXV, MINV, 0});
        issue_tensor(operand_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, HALF});
    endtask

    task automatic test_full_3d();
        // upper bits of the mode word are junk; only bit 0 selects 3D
        set_config(32'hFFFF_FFFF, 32'sd131072, 32'sd65536, 32'sd167772);
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, MAXV});
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE + HALF, 0});
        issue_tensor(operand_t'{ONE, HALF, ONE / 4, -HALF, ONE, HALF, ONE / 8, -ONE / 4,
                                ONE, 0});
        issue_tensor(operand_t'{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE, 0});
    endtask

    task automatic test_saturation();
        set_config(32'h0000_0002, MINV, MAXV, MAXV);
        issue_tensor(operand_t'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        issue_tensor(operand_t'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
        issue_tensor(operand_t'{MAXV, MINV, 0, MINV, MAXV, 0, 0, 0, 0, MINV});
        issue_tensor(operand_t'{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, MAXV});
        set_config(32'h0000_0001, MAXV, MINV, MINV);
        issue_tensor(operand_t'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        issue_tensor(operand_t'{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
        issue_tensor(operand_t'{MAXV, 0, MINV, 0, MINV, 0, MINV, 0, MAXV, 0});
        issue_tensor(operand_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    endtask

    task automatic test_random();
        logic [31:0] mode_word;
        logic [31:0] lame;
        logic [31:0] mu;
        logic [31:0] beta;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            mode_word = $urandom();
            mode_word[0] = p[0];
            lame = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : jitter(1 << 24);
            mu = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : jitter(1 << 24);
            beta = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : jitter(1 << 21);
            set_config(mode_word, lame, mu, beta);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 45 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                issue_tensor(random_tensor());
            end
        end
        no_gaps = 0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_plane_thermal();
        test_full_3d();
        test_saturation();
        test_random();
        quiesce();
        if (mismatches == 0 && expected_stress.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/svk_pkg.sv
rtl/svk_strain.sv
rtl/svk_law.sv
rtl/svk_stress_and_energy.sv
test/svk_stress_and_energy_tb.sv
